// ===== hdl/pctd_pkg.sv =====
// package: sizes, microcode step and condition codes, control word and program rom
`default_nettype none

package pctd_pkg;

	// default sizes
	localparam int VALUE_BITS_DEF = 32;
	localparam int COUNT_BITS_DEF = 16;

	// program steps
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_LOOP,
		ST_DIV,
		ST_DIV_END,
		ST_RESULT
	} step_t;

	// jump conditions
	typedef enum logic [2:0] {
		C_NONE,
		C_ACCEPT,
		C_TRIVIAL,
		C_SQ_GT,
		C_DIV_LAST,
		C_REM_ZERO,
		C_OUT_FREE
	} cond_t;

	// one control word
	typedef struct packed {
		logic  in_rdy;       // input request may be taken
		logic  ld_val;       // load value and last, gated by the jump
		logic  set_small;    // prime flag from the 2 or 3 shortcut
		logic  prime_on_hit; // prime flag set when the jump is taken
		logic  init_div;     // restart the remainder unit
		logic  div_step;     // one restoring remainder bit
		logic  inc_d;        // next divisor and its square
		logic  wr_out;       // write result register, gated by the jump
		cond_t cond;
		step_t target;       // step when the condition holds
		step_t next;         // step otherwise
	} ctrl_t;

	// program rom
	function automatic ctrl_t ucode(input step_t s);
		ctrl_t w;
		begin
			w = '{in_rdy: 1'b0, ld_val: 1'b0, set_small: 1'b0, prime_on_hit: 1'b0,
				init_div: 1'b0, div_step: 1'b0, inc_d: 1'b0, wr_out: 1'b0,
				cond: C_NONE, target: ST_IDLE, next: ST_IDLE};
			case (s)
				ST_IDLE: begin
					w.in_rdy = 1'b1;
					w.ld_val = 1'b1;
					w.cond   = C_ACCEPT;
					w.target = ST_CHECK;
					w.next   = ST_IDLE;
				end
				ST_CHECK: begin
					w.set_small = 1'b1;
					w.cond      = C_TRIVIAL;
					w.target    = ST_RESULT;
					w.next      = ST_LOOP;
				end
				ST_LOOP: begin
					w.prime_on_hit = 1'b1;
					w.init_div     = 1'b1;
					w.cond         = C_SQ_GT;
					w.target       = ST_RESULT;
					w.next         = ST_DIV;
				end
				ST_DIV: begin
					w.div_step = 1'b1;
					w.cond     = C_DIV_LAST;
					w.target   = ST_DIV_END;
					w.next     = ST_DIV;
				end
				ST_DIV_END: begin
					w.inc_d  = 1'b1;
					w.cond   = C_REM_ZERO;
					w.target = ST_RESULT;
					w.next   = ST_LOOP;
				end
				ST_RESULT: begin
					w.wr_out = 1'b1;
					w.cond   = C_OUT_FREE;
					w.target = ST_IDLE;
					w.next   = ST_RESULT;
				end
				default: begin
					w.next = ST_IDLE;
				end
			endcase
			return w;
		end
	endfunction

endpackage

`default_nettype wire

// ===== hdl/prime_counter_trial_division.sv =====
// top level: microcoded trial division primality test with per-sequence prime count
//
// input stream s_*: one signed value per request in s_tdata, s_tlast marks the
// final value of a sequence. output stream m_*: one result per input request,
// prime flag and running prime count in m_tdata, m_tlast copies the input last.
// the count saturates at all ones and clears after the result of a last request.
// values below 2, 2 and 3 skip the loop: the check step passes them straight to the
// result step. other values run a loop per trial divisor (loop test, one restoring
// remainder bit per cycle, remainder check), for divisors 2 up to floor(sqrt(value)),
// ending at the first divisor that leaves remainder zero; one bit-serial remainder
// unit serves every divisor. a 32-bit prime near the top runs divisors up to 46340.
// one value is processed at a time; s_tready is high only while the sequencer
// waits in its idle step, which it reaches once the result sits in the output
// register, so the next value can start while that result is still waiting.
// if m_tready stays low the result holds and the sequencer waits at its result
// step with the next finished result. reset clears the step counter, the count
// and the output valid.
`default_nettype none

module prime_counter_trial_division
	import pctd_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // value
	input  wire logic                                 s_tlast,  // last
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic [((COUNT_BITS + 8) / 8) * 8 - 1:0]   m_tdata,  // prime flag, prime_count
	output logic                                      m_tlast   // done_res
);

	localparam int OUT_W = ((COUNT_BITS + 8) / 8) * 8;
	localparam int BIT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
	localparam logic [VALUE_BITS-1:0] TWO   = VALUE_BITS'(2);
	localparam logic [VALUE_BITS-1:0] THREE = VALUE_BITS'(3);

	// sequencer and datapath registers
	step_t                  step_q;
	logic [VALUE_BITS-1:0]  val_q;
	logic                   last_q;
	logic                   prime_q;
	logic [VALUE_BITS-1:0]  d_q;
	logic [VALUE_BITS:0]    sq_q;
	logic [VALUE_BITS-1:0]  rem_q;
	logic [VALUE_BITS-1:0]  dvd_q;
	logic [BIT_W-1:0]       bit_q;
	logic [COUNT_BITS-1:0]  cnt_q;
	logic                   out_valid_q;
	logic                   out_prime_q;
	logic [COUNT_BITS-1:0]  out_cnt_q;
	logic                   out_last_q;

	ctrl_t                  ctrl;
	logic                   hit;
	step_t                  step_d;
	logic                   is_small;
	logic                   trivial;
	logic [VALUE_BITS:0]    div_tmp;
	logic                   div_ge;
	logic [COUNT_BITS-1:0]  cnt_new;

	// value classification
	always_comb begin
		is_small = (val_q == TWO) || (val_q == THREE);
		trivial  = val_q[VALUE_BITS-1] || (val_q < TWO) || is_small;
	end

	// condition select and next step
	always_comb begin
		ctrl = ucode(step_q);
		case (ctrl.cond)
			C_NONE:     hit = 1'b0;
			C_ACCEPT:   hit = s_tvalid;
			C_TRIVIAL:  hit = trivial;
			C_SQ_GT:    hit = sq_q > {1'b0, val_q};
			C_DIV_LAST: hit = (bit_q == '0);
			C_REM_ZERO: hit = (rem_q == '0);
			C_OUT_FREE: hit = !out_valid_q || m_tready;
			default:    hit = 1'b0;
		endcase
		step_d = hit ? ctrl.target : ctrl.next;
	end

	// remainder step and count update
	always_comb begin
		div_tmp = {rem_q, dvd_q[VALUE_BITS-1]};
		div_ge  = div_tmp >= {1'b0, d_q};
		cnt_new = (prime_q && (cnt_q != '1)) ? cnt_q + COUNT_BITS'(1) : cnt_q;
	end

	// step counter and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			step_q <= step_d;
			if (ctrl.wr_out && hit) begin
				cnt_q       <= last_q ? '0 : cnt_new;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (ctrl.ld_val && hit) begin
			val_q  <= s_tdata[VALUE_BITS-1:0];
			last_q <= s_tlast;
		end
		if (ctrl.set_small) begin
			prime_q <= is_small;
			d_q     <= TWO;
			sq_q    <= (VALUE_BITS + 1)'(4);
		end
		if (ctrl.prime_on_hit && hit) begin
			prime_q <= 1'b1;
		end
		if (ctrl.init_div) begin
			rem_q <= '0;
			dvd_q <= val_q;
			bit_q <= BIT_W'(VALUE_BITS - 1);
		end
		if (ctrl.div_step) begin
			rem_q <= div_ge ? VALUE_BITS'(div_tmp - {1'b0, d_q}) : div_tmp[VALUE_BITS-1:0];
			dvd_q <= {dvd_q[VALUE_BITS-2:0], 1'b0};
			bit_q <= bit_q - BIT_W'(1);
		end
		if (ctrl.inc_d) begin
			d_q  <= d_q + VALUE_BITS'(1);
			sq_q <= sq_q + {d_q, 1'b1};
		end
		if (ctrl.wr_out && hit) begin
			out_prime_q <= prime_q;
			out_cnt_q   <= cnt_new;
			out_last_q  <= last_q;
		end
	end

	// ports
	assign s_tready = ctrl.in_rdy;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({out_cnt_q, out_prime_q});
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

// ===== test/prime_counter_trial_division_tb.sv =====
// testbench: trial division prime counter checked against its own verdict predictor
`timescale 1ns / 1ps

module prime_counter_trial_division_tb
	import pctd_pkg::*;
();

	localparam int VALUE_W     = VALUE_BITS_DEF;
	localparam int COUNT_W     = COUNT_BITS_DEF;
	localparam int S_DATA_W    = ((VALUE_W + 7) / 8) * 8;
	localparam int M_DATA_W    = ((COUNT_W + 8) / 8) * 8;
	localparam int STALL_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 40;
	localparam int N_DIRECTED  = 24;
	localparam int N_RANDOM    = 76;
	localparam int N_STEADY    = 40;

	// one predicted result
	typedef struct packed {
		logic               prime;
		logic [COUNT_W-1:0] count;
		logic               done;
	} verdict_t;

	// one directed request, with a typed result where it is obvious
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
		logic               typed;
		logic               prime;
		logic [COUNT_W-1:0] count;
	} probe_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata  = '0;  // value
	logic                s_tlast  = 1'b0; // last
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;        // prime flag, prime_count
	logic                m_tlast;        // done_res

	verdict_t           pending_verdicts[$];
	logic [COUNT_W-1:0] prime_tally  = '0;
	bit                 steady_phase = 1'b0;
	int                 mismatches   = 0;
	int                 stall_cycles = 0;
	int                 n_requests   = 0;
	int                 n_sequences  = 0;
	int                 n_primes     = 0;

	probe_t directed_probes [N_DIRECTED] = '{
		'{32'h0000_0000, 1'b0, 1'b1, 1'b0, 16'd0},
		'{32'h0000_0001, 1'b0, 1'b1, 1'b0, 16'd0},
		'{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 16'd0},
		'{32'h8000_0000, 1'b0, 1'b1, 1'b0, 16'd0},
		'{32'h0000_0002, 1'b0, 1'b1, 1'b1, 16'd1},
		'{32'h0000_0003, 1'b1, 1'b1, 1'b1, 16'd2},
		'{32'h0000_0002, 1'b1, 1'b1, 1'b1, 16'd1},
		'{32'h0000_0004, 1'b0, 1'b1, 1'b0, 16'd0},
		'{32'd9,         1'b0, 1'b0, 1'b0, 16'd0},
		'{32'd25,        1'b0, 1'b0, 1'b0, 16'd0},
		'{32'd49,        1'b0, 1'b0, 1'b0, 16'd0},
		'{32'd5,         1'b0, 1'b0, 1'b0, 16'd0},
		'{32'd7,         1'b0, 1'b0, 1'b0, 16'd0},
		'{32'd97,        1'b0, 1'b0, 1'b0, 16'd0},
		'{32'd121,       1'b0, 1'b0, 1'b0, 16'd0},
		'{32'd65521,     1'b0, 1'b0, 1'b0, 16'd0},
		'{32'd1000001,   1'b0, 1'b0, 1'b0, 16'd0},
		'{32'd1000003,   1'b0, 1'b0, 1'b0, 16'd0},
		'{32'h7FFF_FFFE, 1'b0, 1'b0, 1'b0, 16'd0},
		'{32'h7FFF_FFFD, 1'b0, 1'b0, 1'b0, 16'd0},
		'{32'h8000_0001, 1'b0, 1'b0, 1'b0, 16'd0},
		'{32'h5555_5555, 1'b0, 1'b0, 1'b0, 16'd0},
		'{32'h2AAA_AAAA, 1'b0, 1'b0, 1'b0, 16'd0},
		'{32'hFFFF_FFFE, 1'b1, 1'b0, 1'b0, 16'd0}
	};

	prime_counter_trial_division DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// primality by trial division, negatives and values below 2 are not prime
	function automatic logic check_by_division(input logic [VALUE_W-1:0] raw);
		longint unsigned n;
		longint unsigned d;
		if (raw[VALUE_W-1])
			return 1'b0;
		n = 64'(raw);
		if (n < 2)
			return 1'b0;
		if (n == 2 || n == 3)
			return 1'b1;
		for (d = 2; d <= n / d; d++) begin
			if (n % d == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// advance the running prime tally for one request and return its verdict
	function automatic verdict_t tally_request(input logic [VALUE_W-1:0] value, input logic last);
		verdict_t v;
		v.prime = check_by_division(value);
		if (v.prime && prime_tally != '1)
			prime_tally = prime_tally + COUNT_W'(1);
		v.count = prime_tally;
		v.done  = last;
		if (last)
			prime_tally = '0;
		n_requests++;
		n_primes    += int'(v.prime);
		n_sequences += int'(last);
		return v;
	endfunction

	task automatic note_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	// random value: mostly small, plus negatives and fast large composites
	function automatic logic [VALUE_W-1:0] pick_value();
		logic [VALUE_W-1:0] v;
		int unsigned        k;
		int unsigned        sel;
		sel = $urandom_range(99);
		if (sel < 50) begin
			v = $urandom_range(1023);
		end else if (sel < 65) begin
			v = $urandom_range(65535, 1024);
		end else if (sel < 80) begin
			v = $urandom | 32'h8000_0000;
		end else if (sel < 95) begin
			// large positive with a small factor so the loop ends early
			v = $urandom & 32'h7FFF_FFFF;
			k = $urandom_range(3);
			k = (k == 0) ? 2 : (k == 1) ? 3 : (k == 2) ? 5 : 7;
			v = v - (v % k);
		end else begin
			v = $urandom_range(3);
		end
		return v;
	endfunction

	// drive one request, optionally idling first, and record its verdict
	task automatic send_request(input logic [VALUE_W-1:0] value, input logic last,
			input bit typed, input verdict_t typed_verdict);
		verdict_t v;
		if (!steady_phase && $urandom_range(99) < 6) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(8, 1)) @(posedge clk);
		end
		s_tdata  <= S_DATA_W'(value);
		s_tlast  <= last;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		v = tally_request(value, last);
		pending_verdicts.push_back(typed ? typed_verdict : v);
	endtask

	task automatic wait_all_results();
		while (pending_verdicts.size() != 0) @(posedge clk);
	endtask

	// result side: random back-pressure and in-order checking
	always @(posedge clk) begin : take_results
		verdict_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_verdicts.size() == 0) begin
				note_mismatch("result with no request pending");
			end else begin
				want = pending_verdicts.pop_front();
				if (m_tdata[0] !== want.prime)
					note_mismatch($sformatf("prime flag got %b expected %b",
						m_tdata[0], want.prime));
				if (m_tdata[COUNT_W:1] !== want.count)
					note_mismatch($sformatf("prime_count got %0d expected %0d",
						m_tdata[COUNT_W:1], want.count));
				if (m_tlast !== want.done)
					note_mismatch($sformatf("done_res got %b expected %b",
						m_tlast, want.done));
			end
		end
		m_tready <= steady_phase || ($urandom_range(99) >= 6);
	end

	// watchdog on cycles with no request or result moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == STALL_LIMIT) begin
			$display("watchdog: no traffic for %0d cycles, %0d results outstanding",
				STALL_LIMIT, pending_verdicts.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : stimulus
		verdict_t typed_v;
		int       seq_left;
		int       i;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (directed_probes[j]) begin
			typed_v.prime = directed_probes[j].prime;
			typed_v.count = directed_probes[j].count;
			typed_v.done  = directed_probes[j].last;
			send_request(directed_probes[j].value, directed_probes[j].last,
				directed_probes[j].typed, typed_v);
		end

		// hold off until every result is back
		s_tvalid <= 1'b0;
		wait_all_results();

		// random sequences, the first stretch with no idling on either side
		seq_left = 0;
		for (i = 0; i < N_RANDOM; i++) begin
			steady_phase = (i < N_STEADY);
			if (seq_left == 0)
				seq_left = $urandom_range(12, 1);
			seq_left--;
			send_request(pick_value(), seq_left == 0 || i == N_RANDOM - 1, 1'b0, typed_v);
		end
		steady_phase = 1'b0;

		// drain and look for stray results
		s_tvalid <= 1'b0;
		wait_all_results();
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("covered %0d requests in %0d sequences, %0d of them prime",
			n_requests, n_sequences, n_primes);
		$display("mismatches: %0d", mismatches);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/pctd_pkg.sv
hdl/prime_counter_trial_division.sv
test/prime_counter_trial_division_tb.sv
